>>> hw/rtl/hrhp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrhp_pkg: shared types and constants of the response header parser
// Item and result records, command classes, state codes, character constants
// and small character helpers.
// ----------------------------------------------------------------------------
package hrhp_pkg;

  localparam int LINE_BYTES = 512;
  localparam int HOST_BYTES = 64;
  localparam int PATH_BYTES = 128;
  localparam int LINE_AW    = $clog2(LINE_BYTES);
  localparam int HOST_AW    = $clog2(HOST_BYTES);
  localparam int PATH_AW    = $clog2(PATH_BYTES);

  localparam logic [HOST_AW-1:0] HOST_MAX = HOST_AW'(HOST_BYTES - 1);
  localparam logic [PATH_AW-1:0] PATH_MAX = PATH_AW'(PATH_BYTES - 1);

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  // Words are left aligned in eight characters.
  localparam logic [63:0] HTTP_WORD  = {"HTTP/", 24'h0};
  localparam logic [63:0] ICY_WORD   = {"ICY", 40'h0};
  localparam logic [63:0] LOC_WORD   = "location";
  localparam logic [63:0] HTTPS_WORD = {"https", 24'h0};

  localparam logic [15:0] CODE_OK     = 16'd200;
  localparam logic [15:0] CODE_MOVED  = 16'd301;
  localparam logic [15:0] CODE_FOUND  = 16'd302;
  localparam logic [15:0] CODE_MAX    = 16'hFFFF;
  localparam logic [15:0] PORT_HTTP   = 16'd80;
  localparam logic [15:0] PORT_HTTPS  = 16'd443;
  localparam logic [2:0]  PORT_DIGITS = 3'd5;

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_BYTE  = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    CMD_CLEAR,
    CMD_BYTE,
    CMD_LINE_END,
    CMD_READ,
    CMD_NONE
  } cmd_t;

  typedef enum logic [1:0] {
    PS_RUN   = 2'd0,
    PS_OK    = 2'd1,
    PS_REDIR = 2'd2,
    PS_ERROR = 2'd3
  } parse_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_READ,
    BK_A_ISSUE,
    BK_A_USE,
    BK_A_END,
    BK_B_ISSUE,
    BK_B_USE,
    BK_B_END,
    BK_EMIT
  } bk_state_t;

  typedef enum logic [1:0] {
    FL_PRE,
    FL_SKIP,
    FL_DIG,
    FL_STOP
  } fl_phase_t;

  typedef enum logic [1:0] {
    LP_HOST,
    LP_PORT,
    LP_PATH
  } loc_phase_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data;
    logic       which;
    logic [6:0] index;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] code;
    logic        secure;
    logic [15:0] port;
    logic [5:0]  host_len;
    logic [6:0]  path_len;
    logic [7:0]  rbyte;
  } res_t;

  function automatic logic [7:0] lower_of(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic [7:0] word_char(input logic [63:0] w, input logic [2:0] pos);
    logic [5:0] sh;
    sh = {3'd7 - pos, 3'b000};
    return w[sh +: 8];
  endfunction

endpackage

>>> hw/rtl/http_response_header_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_response_header_parser: HTTP and ICY response header parser
// Collects CR LF terminated lines, takes the status code from the status
// line, splits a Location header into scheme, host, port and path, and gives
// one result record for every item transferred in.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                  Payload
//   item      item_valid / item_stall    func, data_byte, read_which, read_index
//   result    result_valid / result_stall status, status_code, secure,
//                                        port_number, host_length, path_length,
//                                        read_byte
//
// Sequence: an ordinary header byte, a clear or a no-op goes from the idle
// state straight to the result state of the back end, and a name read passes
// through the read state first. The back end takes the next item only once
// the result of the previous one has been transferred. A CR LF that closes a
// line starts a scan of the line memory, and a second scan over the value
// when the line is a Location header; each step of a scan waits for the
// registered read of the line memory.
// Reset clears all status and lengths; the line, host and path memories are
// not cleared and are only ever read where they have been written.
// While result_stall is high the finished record stays in the output register
// and the two-entry queue keeps taking items until it is full.
module http_response_header_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  func,
  input  logic [7:0]  data_byte,
  input  logic        read_which,
  input  logic [6:0]  read_index,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  status,
  output logic [15:0] status_code,
  output logic        secure,
  output logic [15:0] port_number,
  output logic [5:0]  host_length,
  output logic [6:0]  path_length,
  output logic [7:0]  read_byte
);

  hrhp_pkg::item_t cls_item;
  hrhp_pkg::item_t q_head;
  hrhp_pkg::res_t  res;
  logic            q_full;
  logic            q_vld;
  logic            q_pop;
  logic            push;

  // The front end classifies every transfer and pushes it into the queue.
  assign item_stall = q_full;
  assign push       = item_valid && !q_full;

  hrhp_front u_front (
    .func       (func),
    .data_byte  (data_byte),
    .read_which (read_which),
    .read_index (read_index),
    .item       (cls_item)
  );

  hrhp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (cls_item),
    .pop       (q_pop),
    .full      (q_full),
    .vld       (q_vld),
    .head      (q_head)
  );

  // The back end owns all parser state and the output register.
  hrhp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_vld     (q_vld),
    .q_item    (q_head),
    .q_pop     (q_pop),
    .res_vld   (result_valid),
    .res_stall (result_stall),
    .res       (res)
  );

  assign status      = res.status;
  assign status_code = res.code;
  assign secure      = res.secure;
  assign port_number = res.port;
  assign host_length = res.host_len;
  assign path_length = res.path_len;
  assign read_byte   = res.rbyte;

endmodule

>>> hw/rtl/hrhp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrhp_front: item classifier
// Turns the raw item fields into a command record for the back end.
// ----------------------------------------------------------------------------
module hrhp_front (
  input  logic [1:0]     func,
  input  logic [7:0]     data_byte,
  input  logic           read_which,
  input  logic [6:0]     read_index,
  output hrhp_pkg::item_t item
);

  always_comb begin
    item.data  = data_byte;
    item.which = read_which;
    item.index = read_index;
    case (hrhp_pkg::func_t'(func))
      hrhp_pkg::FUNC_CLEAR: item.cmd = hrhp_pkg::CMD_CLEAR;
      hrhp_pkg::FUNC_BYTE: begin
        // A line feed may close a line; the back end checks the preceding CR.
        item.cmd = (data_byte == hrhp_pkg::CH_LF) ? hrhp_pkg::CMD_LINE_END
                                                  : hrhp_pkg::CMD_BYTE;
      end
      hrhp_pkg::FUNC_READ: item.cmd = hrhp_pkg::CMD_READ;
      default: item.cmd = hrhp_pkg::CMD_NONE;
    endcase
  end

endmodule

>>> hw/rtl/hrhp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrhp_queue: two-entry command queue
// Decouples the classifier from the back end sequencer.
// ----------------------------------------------------------------------------
module hrhp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  hrhp_pkg::item_t push_item,
  input  logic            pop,
  output logic            full,
  output logic            vld,
  output hrhp_pkg::item_t head
);

  hrhp_pkg::item_t ent [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;

  assign full = (count == 2'd2);
  assign vld  = (count != 2'd0);
  assign head = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= push_item;
    end
  end

endmodule

>>> hw/rtl/hrhp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrhp_back: line store and parsing sequencer
// Stores header bytes, scans completed lines from the line memory and keeps
// the status, code and redirect target. Host and path are double banked so
// that a failed Location header leaves the previous target in place.
// ----------------------------------------------------------------------------
module hrhp_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_vld,
  input  hrhp_pkg::item_t q_item,
  output logic            q_pop,
  output logic            res_vld,
  input  logic            res_stall,
  output hrhp_pkg::res_t  res
);

  localparam int LAW = hrhp_pkg::LINE_AW;
  localparam int HAW = hrhp_pkg::HOST_AW;
  localparam int PAW = hrhp_pkg::PATH_AW;

  hrhp_pkg::bk_state_t  state;
  hrhp_pkg::bk_state_t  state_next;
  hrhp_pkg::item_t      cur;
  hrhp_pkg::parse_t     parse_st;
  hrhp_pkg::parse_t     fin_state;
  hrhp_pkg::fl_phase_t  fl_ph;
  hrhp_pkg::loc_phase_t lp_ph;

  logic [LAW:0]   fill;
  logic [7:0]     last_byte;
  logic [15:0]    code_reg;
  logic           sec_flag;
  logic [15:0]    port_reg;
  logic [HAW-1:0] host_count;
  logic [PAW-1:0] path_count;
  logic           bank;

  logic [LAW-1:0] scan_j;
  logic [LAW-1:0] line_n;
  logic [7:0]     lm_q;

  logic           pfx_http;
  logic           pfx_icy;
  logic [15:0]    acc;
  logic [7:0]     prev1;
  logic [7:0]     prev2;
  logic           colsp;
  logic           name_ok;
  logic           loc_hdr;
  logic           sch_https;
  logic           sch_http;
  logic           css_found;
  logic [LAW-1:0] begin_j;

  logic [HAW-1:0] hcnt;
  logic           h_over;
  logic [PAW-1:0] pcnt;
  logic           p_over;
  logic           has_port;
  logic [2:0]     port_cnt;
  logic [16:0]    port_val;
  logic           port_run;
  logic           sec_s;
  logic [15:0]    port_s;

  logic [7:0] line_mem [hrhp_pkg::LINE_BYTES];
  logic [7:0] host_mem [2*hrhp_pkg::HOST_BYTES];
  logic [7:0] path_mem [2*hrhp_pkg::PATH_BYTES];
  logic [7:0] h_q;
  logic [7:0] p_q;

  logic           is_byte;
  logic           end_hit;
  logic           store_en;
  logic [7:0]     c;
  logic [7:0]     c_low;
  logic           c_dig;
  logic [3:0]     dval;
  logic [19:0]    acc_mul;
  logic [20:0]    port_mul;
  logic [LAW-1:0] val_len;
  logic [LAW-1:0] kpos;
  logic           scheme_ok;
  logic           sec_sel;
  logic [15:0]    port_sel;
  logic [LAW-1:0] start_j;
  logic           go_b;
  logic           b_slash;
  logic           b_colon;
  logic           hw_en;
  logic [HAW:0]   hw_addr;
  logic           pw_en;
  logic [PAW:0]   pw_addr;
  logic           loc_ok;
  logic           rd_ok;

  assign q_pop   = (state == hrhp_pkg::BK_IDLE) && q_vld && !res_vld;
  assign is_byte = (q_item.cmd == hrhp_pkg::CMD_BYTE) ||
                   (q_item.cmd == hrhp_pkg::CMD_LINE_END);
  assign end_hit = (q_item.cmd == hrhp_pkg::CMD_LINE_END) &&
                   (parse_st == hrhp_pkg::PS_RUN) && (fill != '0) &&
                   (last_byte == hrhp_pkg::CH_CR);
  assign store_en = q_pop && is_byte && (parse_st == hrhp_pkg::PS_RUN) && !end_hit &&
                    (fill != (LAW+1)'(hrhp_pkg::LINE_BYTES));

  assign c        = lm_q;
  assign c_low    = hrhp_pkg::lower_of(lm_q);
  assign c_dig    = hrhp_pkg::is_digit(lm_q);
  assign dval     = 4'(lm_q - hrhp_pkg::CH_ZERO);
  assign acc_mul  = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {16'd0, dval};
  assign port_mul = {1'b0, port_val, 3'b000} + {3'b000, port_val, 1'b0} + {17'd0, dval};
  assign val_len  = line_n - LAW'(10);
  assign kpos     = scan_j - LAW'(10);
  assign b_slash  = (c == hrhp_pkg::CH_SLASH);
  assign b_colon  = (c == hrhp_pkg::CH_COLON);

  always_comb begin
    fin_state = hrhp_pkg::PS_ERROR;
    if (code_reg == hrhp_pkg::CODE_OK) begin
      fin_state = hrhp_pkg::PS_OK;
    end else if ((code_reg == hrhp_pkg::CODE_MOVED || code_reg == hrhp_pkg::CODE_FOUND) &&
                 host_count != '0 && path_count != '0 && port_reg != 16'd0) begin
      fin_state = hrhp_pkg::PS_REDIR;
    end
  end

  // Scheme decision at the end of the first pass over a Location line.
  always_comb begin
    scheme_ok = 1'b1;
    sec_sel   = 1'b0;
    port_sel  = hrhp_pkg::PORT_HTTP;
    start_j   = LAW'(10);
    if (css_found) begin
      start_j = begin_j;
      if (sch_https && val_len >= LAW'(5)) begin
        sec_sel  = 1'b1;
        port_sel = hrhp_pkg::PORT_HTTPS;
      end else if (!(sch_http && val_len >= LAW'(4))) begin
        scheme_ok = 1'b0;
      end
    end
    go_b = (code_reg != 16'd0) && loc_hdr && scheme_ok && (start_j < line_n);
  end

  always_comb begin
    hw_en   = (state == hrhp_pkg::BK_B_USE) && (lp_ph == hrhp_pkg::LP_HOST) &&
              !b_slash && !b_colon && (hcnt != hrhp_pkg::HOST_MAX);
    hw_addr = {~bank, hcnt};
    pw_en   = (state == hrhp_pkg::BK_B_USE) &&
              (((lp_ph != hrhp_pkg::LP_PATH) && b_slash) ||
               ((lp_ph == hrhp_pkg::LP_PATH) && (pcnt != hrhp_pkg::PATH_MAX)));
    pw_addr = {~bank, (lp_ph == hrhp_pkg::LP_PATH) ? pcnt : PAW'(0)};
  end

  assign loc_ok = (lp_ph == hrhp_pkg::LP_PATH) && !h_over && !p_over &&
                  (!has_port || (port_cnt <= hrhp_pkg::PORT_DIGITS && port_val != 17'd0 &&
                                 port_val <= 17'd65535));

  assign rd_ok = cur.which ? (cur.index < path_count) : (cur.index < {1'b0, host_count});

  always_ff @(posedge clk) begin
    if (store_en) begin
      line_mem[fill[LAW-1:0]] <= q_item.data;
    end
    lm_q <= line_mem[scan_j];
  end

  always_ff @(posedge clk) begin
    if (hw_en) begin
      host_mem[hw_addr] <= c;
    end
    if (pw_en) begin
      path_mem[pw_addr] <= c;
    end
    h_q <= host_mem[{bank, cur.index[HAW-1:0]}];
    p_q <= path_mem[{bank, cur.index[PAW-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hrhp_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      hrhp_pkg::BK_IDLE: begin
        if (q_pop) begin
          if (q_item.cmd == hrhp_pkg::CMD_READ) begin
            state_next = hrhp_pkg::BK_READ;
          end else if (end_hit && fill != (LAW+1)'(1)) begin
            state_next = hrhp_pkg::BK_A_ISSUE;
          end else begin
            state_next = hrhp_pkg::BK_EMIT;
          end
        end
      end
      hrhp_pkg::BK_READ:    state_next = hrhp_pkg::BK_EMIT;
      hrhp_pkg::BK_A_ISSUE: state_next = hrhp_pkg::BK_A_USE;
      hrhp_pkg::BK_A_USE: begin
        state_next = (scan_j == line_n - LAW'(1)) ? hrhp_pkg::BK_A_END
                                                  : hrhp_pkg::BK_A_ISSUE;
      end
      hrhp_pkg::BK_A_END: begin
        state_next = go_b ? hrhp_pkg::BK_B_ISSUE : hrhp_pkg::BK_EMIT;
      end
      hrhp_pkg::BK_B_ISSUE: state_next = hrhp_pkg::BK_B_USE;
      hrhp_pkg::BK_B_USE: begin
        state_next = (scan_j == line_n - LAW'(1)) ? hrhp_pkg::BK_B_END
                                                  : hrhp_pkg::BK_B_ISSUE;
      end
      hrhp_pkg::BK_B_END: state_next = hrhp_pkg::BK_EMIT;
      hrhp_pkg::BK_EMIT:  state_next = hrhp_pkg::BK_IDLE;
      default:            state_next = hrhp_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      code_reg   <= 16'd0;
      parse_st   <= hrhp_pkg::PS_RUN;
      sec_flag   <= 1'b0;
      port_reg   <= 16'd0;
      host_count <= '0;
      path_count <= '0;
      bank       <= 1'b0;
      res_vld    <= 1'b0;
    end else begin
      if (res_vld && !res_stall) begin
        res_vld <= 1'b0;
      end
      case (state)
        hrhp_pkg::BK_IDLE: begin
          if (q_pop) begin
            cur <= q_item;
            if (q_item.cmd == hrhp_pkg::CMD_CLEAR) begin
              fill       <= '0;
              code_reg   <= 16'd0;
              parse_st   <= hrhp_pkg::PS_RUN;
              sec_flag   <= 1'b0;
              port_reg   <= 16'd0;
              host_count <= '0;
              path_count <= '0;
            end else if (is_byte && parse_st == hrhp_pkg::PS_RUN) begin
              if (end_hit) begin
                fill   <= '0;
                line_n <= LAW'(fill - (LAW+1)'(1));
                scan_j <= '0;
                if (fill == (LAW+1)'(1)) begin
                  parse_st <= fin_state;
                end
                pfx_http  <= 1'b1;
                pfx_icy   <= 1'b1;
                fl_ph     <= hrhp_pkg::FL_PRE;
                acc       <= 16'd0;
                colsp     <= 1'b0;
                name_ok   <= 1'b1;
                loc_hdr   <= 1'b0;
                sch_https <= 1'b1;
                sch_http  <= 1'b1;
                css_found <= 1'b0;
              end else if (store_en) begin
                fill      <= fill + (LAW+1)'(1);
                last_byte <= q_item.data;
              end else begin
                parse_st <= hrhp_pkg::PS_ERROR;
              end
            end
          end
        end
        hrhp_pkg::BK_A_USE: begin
          scan_j <= scan_j + LAW'(1);
          prev1  <= c;
          prev2  <= prev1;
          if (scan_j < LAW'(5) && c != hrhp_pkg::word_char(hrhp_pkg::HTTP_WORD, scan_j[2:0])) begin
            pfx_http <= 1'b0;
          end
          if (scan_j < LAW'(3) && c != hrhp_pkg::word_char(hrhp_pkg::ICY_WORD, scan_j[2:0])) begin
            pfx_icy <= 1'b0;
          end
          case (fl_ph)
            hrhp_pkg::FL_PRE: begin
              if (c == hrhp_pkg::CH_SPACE) begin
                fl_ph <= hrhp_pkg::FL_SKIP;
              end
            end
            hrhp_pkg::FL_SKIP, hrhp_pkg::FL_DIG: begin
              if (c_dig) begin
                fl_ph <= hrhp_pkg::FL_DIG;
                acc   <= (acc_mul > 20'hFFFF) ? hrhp_pkg::CODE_MAX : acc_mul[15:0];
              end else if (!(fl_ph == hrhp_pkg::FL_SKIP && c == hrhp_pkg::CH_SPACE)) begin
                fl_ph <= hrhp_pkg::FL_STOP;
              end
            end
            default: fl_ph <= hrhp_pkg::FL_STOP;
          endcase
          // Header name must be "location" and the first ": " right after it.
          if (scan_j < LAW'(8) &&
              c_low != hrhp_pkg::word_char(hrhp_pkg::LOC_WORD, scan_j[2:0])) begin
            name_ok <= 1'b0;
          end
          if (scan_j != '0 && prev1 == hrhp_pkg::CH_COLON && c == hrhp_pkg::CH_SPACE &&
              !colsp) begin
            colsp <= 1'b1;
            if (scan_j == LAW'(9) && name_ok) begin
              loc_hdr <= 1'b1;
            end
          end
          if (loc_hdr) begin
            if (kpos < LAW'(5) &&
                c_low != hrhp_pkg::word_char(hrhp_pkg::HTTPS_WORD, kpos[2:0])) begin
              sch_https <= 1'b0;
            end
            if (kpos < LAW'(4) &&
                c_low != hrhp_pkg::word_char(hrhp_pkg::HTTPS_WORD, kpos[2:0])) begin
              sch_http <= 1'b0;
            end
            if (!css_found && scan_j >= LAW'(12) && prev2 == hrhp_pkg::CH_COLON &&
                prev1 == hrhp_pkg::CH_SLASH && c == hrhp_pkg::CH_SLASH) begin
              css_found <= 1'b1;
              begin_j   <= scan_j + LAW'(1);
            end
          end
        end
        hrhp_pkg::BK_A_END: begin
          if (code_reg == 16'd0) begin
            if ((pfx_http && line_n >= LAW'(5)) || (pfx_icy && line_n >= LAW'(3))) begin
              if (fl_ph == hrhp_pkg::FL_PRE || acc == 16'd0) begin
                parse_st <= hrhp_pkg::PS_ERROR;
              end else begin
                code_reg   <= acc;
                sec_flag   <= 1'b0;
                port_reg   <= 16'd0;
                host_count <= '0;
                path_count <= '0;
              end
            end
          end
          scan_j   <= start_j;
          sec_s    <= sec_sel;
          port_s   <= port_sel;
          lp_ph    <= hrhp_pkg::LP_HOST;
          hcnt     <= '0;
          h_over   <= 1'b0;
          pcnt     <= '0;
          p_over   <= 1'b0;
          has_port <= 1'b0;
          port_cnt <= 3'd0;
          port_val <= 17'd0;
          port_run <= 1'b1;
        end
        hrhp_pkg::BK_B_USE: begin
          scan_j <= scan_j + LAW'(1);
          case (lp_ph)
            hrhp_pkg::LP_HOST: begin
              if (b_slash) begin
                lp_ph <= hrhp_pkg::LP_PATH;
                pcnt  <= PAW'(1);
              end else if (b_colon) begin
                lp_ph    <= hrhp_pkg::LP_PORT;
                has_port <= 1'b1;
              end else if (hcnt == hrhp_pkg::HOST_MAX) begin
                h_over <= 1'b1;
              end else begin
                hcnt <= hcnt + HAW'(1);
              end
            end
            hrhp_pkg::LP_PORT: begin
              if (b_slash) begin
                lp_ph <= hrhp_pkg::LP_PATH;
                pcnt  <= PAW'(1);
              end else begin
                if (port_cnt != 3'd6) begin
                  port_cnt <= port_cnt + 3'd1;
                end
                if (!c_dig) begin
                  port_run <= 1'b0;
                end else if (port_run && port_cnt < hrhp_pkg::PORT_DIGITS) begin
                  port_val <= port_mul[16:0];
                end
              end
            end
            default: begin
              if (pcnt == hrhp_pkg::PATH_MAX) begin
                p_over <= 1'b1;
              end else begin
                pcnt <= pcnt + PAW'(1);
              end
            end
          endcase
        end
        hrhp_pkg::BK_B_END: begin
          if (loc_ok) begin
            host_count <= hcnt;
            path_count <= pcnt;
            sec_flag   <= sec_s;
            port_reg   <= has_port ? port_val[15:0] : port_s;
            bank       <= ~bank;
          end
        end
        hrhp_pkg::BK_EMIT: begin
          res_vld      <= 1'b1;
          res.status   <= parse_st;
          res.code     <= code_reg;
          res.secure   <= sec_flag;
          res.port     <= port_reg;
          res.host_len <= host_count;
          res.path_len <= path_count;
          res.rbyte    <= (cur.cmd == hrhp_pkg::CMD_READ && rd_ok) ? (cur.which ? p_q : h_q)
                                                                  : 8'd0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule
